// File: rtl/gec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the gamepad event conditioner.
// No dependencies; imported by gec_ctrl, gec_dp and the top level.
package gec_pkg;

  localparam int AXIS_COUNT   = 6;
  localparam int BUTTON_COUNT = 15;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 16;
  localparam int LAST_SUB     = AXIS_COUNT + BUTTON_COUNT - 1;
  localparam int LAST_PLAIN   = 10;

  localparam logic [1:0] KIND_AXIS   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_ATTACH = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [1:0] EV_BUTTON  = 2'd0;
  localparam logic [1:0] EV_DPAD    = 2'd1;
  localparam logic [1:0] EV_STICK   = 2'd2;
  localparam logic [1:0] EV_TRIGGER = 2'd3;

  localparam logic [3:0] DIR_C  = 4'd0;
  localparam logic [3:0] DIR_N  = 4'd1;
  localparam logic [3:0] DIR_NE = 4'd2;
  localparam logic [3:0] DIR_E  = 4'd3;
  localparam logic [3:0] DIR_SE = 4'd4;
  localparam logic [3:0] DIR_S  = 4'd5;
  localparam logic [3:0] DIR_SW = 4'd6;
  localparam logic [3:0] DIR_W  = 4'd7;
  localparam logic [3:0] DIR_NW = 4'd8;

  localparam logic [3:0] BTN_UP    = 4'd11;
  localparam logic [3:0] BTN_DOWN  = 4'd12;
  localparam logic [3:0] BTN_LEFT  = 4'd13;
  localparam logic [3:0] BTN_RIGHT = 4'd14;

  localparam logic REG_QUIET = 1'b0;
  localparam logic REG_DZ    = 1'b1;

  typedef struct packed {
    logic [1:0]         event_type;
    logic [3:0]         which;
    logic               is_pressed;
    logic [3:0]         direction;
    logic [15:0]        angle;
    logic [15:0]        distance;
    logic signed [15:0] trigger_level;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_CHECK, ST_MUL0, ST_MUL1, ST_MUL2, ST_INIT, ST_ITER,
    ST_DPREP, ST_DIV, ST_FIN, ST_EMIT, ST_NEXT, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic take;
    logic eval;
    logic mul0;
    logic mul1;
    logic mul2;
    logic init;
    logic iter;
    logic dprep;
    logic div;
    logic fin;
    logic emit;
    logic next;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic need_stick;
    logic cand_ok;
    logic iter_last;
    logic div_last;
    logic emit_ok;
    logic pend_v;
    logic out_free;
    logic sub_more;
  } sts_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dpad_dir(input logic up, input logic dn,
                                          input logic lf, input logic rt);
    logic l;
    logic r;
    logic [3:0] d;
    l = lf && !rt;
    r = rt && !lf;
    if (up && !dn)      d = l ? DIR_NW : (r ? DIR_NE : DIR_N);
    else if (dn && !up) d = l ? DIR_SW : (r ? DIR_SE : DIR_S);
    else if (l)         d = DIR_W;
    else if (r)         d = DIR_E;
    else                d = DIR_C;
    return d;
  endfunction

endpackage

// File: rtl/gec_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the gamepad event conditioner: walks each event through
// gate, stick math and result hand-off. Depends on gec_pkg.
module gec_ctrl
  import gec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.take   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.need_stick)   state_next = ST_MUL0;
        else if (sts.cand_ok) state_next = ST_EMIT;
        else                  state_next = ST_NEXT;
      end
      ST_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_last) state_next = ST_DPREP;
      end
      ST_DPREP: begin
        cmd.dprep  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_EMIT: begin
        if (sts.emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.next   = 1'b1;
        state_next = sts.sub_more ? ST_EVAL : ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!sts.pend_v) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/gec_dp.sv
`timescale 1ns / 1ps
// Datapath of the gamepad event conditioner: state stores, quiet gate,
// CORDIC angle, bit-serial sqrt, restoring divider, result staging.
// Depends on gec_pkg.
module gec_dp
  import gec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_kind,
  input  logic [3:0]         in_index,
  input  logic signed [15:0] in_axis_value,
  input  logic               in_pressed,
  input  logic [31:0]        in_time_ms,
  input  logic [15:0]        attach_quiet_ms,
  input  logic [14:0]        dead_zone,
  input  logic               out_ready,
  output res_t               out_res,
  output logic               out_last,
  output logic               out_valid
);

  // latched input beat
  logic [1:0]         kind_r;
  logic [3:0]         idx_r;
  logic signed [15:0] val_r;
  logic               pr_r;
  logic [31:0]        now_r;
  logic [4:0]         sub;

  // controller state
  logic signed [15:0] axis_store [AXIS_COUNT];
  logic [BUTTON_COUNT-1:0] btn;
  logic [1:0]  stick_t;
  logic [1:0]  trig_t;
  logic [31:0] stamp;
  logic        present;

  logic        need_stick;
  logic        cand_ok;
  res_t        cand;
  logic        st_sel;

  // stick math
  logic signed [15:0] xr;
  logic signed [15:0] yr;
  logic [31:0]        p;
  logic [31:0]        r2;
  logic signed [35:0] cu;
  logic signed [35:0] cv;
  logic [31:0]        acc;
  logic               czero;
  logic [49:0]        sq_n;
  logic [49:0]        sq_r;
  logic [49:0]        sq_bit;
  logic [4:0]         step;
  logic [55:0]        rem;
  logic [55:0]        dsh;
  logic [15:0]        q;
  logic               dzero;
  logic               dsat;

  res_t pend;
  logic pend_v;

  // current sub-event (a remove walks all axes then all buttons)
  logic               is_rm;
  logic [1:0]         e_kind;
  logic [3:0]         e_idx;
  logic signed [15:0] e_val;
  logic               e_pr;
  logic [2:0]         raddr;
  logic signed [15:0] rd;
  logic               axis_ok;
  logic               btn_ok;
  logic               gate_block;
  logic               pass_gate;
  logic               eval_need;
  logic               eval_cand;
  logic [31:0]        elapsed;
  logic               changed;
  logic [BUTTON_COUNT-1:0] btn_next;
  logic               trig_tilt;
  logic signed [31:0] prod;
  logic signed [35:0] ysx;
  logic signed [35:0] xsx;
  logic signed [35:0] u0;
  logic signed [35:0] v0;
  logic [49:0]        sq_t;
  logic [38:0]        a_s;
  logic [29:0]        dz_m;
  logic [37:0]        thr;
  logic [15:0]        om;
  logic [30:0]        den_m;
  logic [38:0]        den;
  logic [54:0]        num;
  logic [15:0]        stick_dist;
  logic [31:0]        acc_rnd;
  logic               out_free;
  logic               end_of_item;

  assign is_rm   = (kind_r == KIND_REMOVE);
  assign e_kind  = is_rm ? ((sub < 5'(AXIS_COUNT)) ? KIND_AXIS : KIND_BUTTON) : kind_r;
  assign e_idx   = is_rm ? ((sub < 5'(AXIS_COUNT)) ? sub[3:0]
                                                   : 4'(sub - 5'(AXIS_COUNT)))
                         : idx_r;
  assign e_val   = is_rm ? 16'sd0 : val_r;
  assign e_pr    = is_rm ? 1'b0 : pr_r;

  always_comb begin
    priority if (cmd.mul0) raddr = {1'b0, st_sel, 1'b0};
    else if (cmd.mul1)     raddr = {1'b0, st_sel, 1'b1};
    else                   raddr = e_idx[2:0];
  end
  assign rd = (raddr < 3'(AXIS_COUNT)) ? axis_store[raddr] : 16'sd0;

  assign axis_ok    = (e_kind == KIND_AXIS) && (e_idx < 4'(AXIS_COUNT));
  assign btn_ok     = (e_kind == KIND_BUTTON) && (e_idx < 4'(BUTTON_COUNT));
  assign elapsed    = now_r - stamp;
  assign gate_block = !present || ((stamp != 32'd0) && (elapsed <= {16'd0, attach_quiet_ms}));
  assign changed    = axis_ok ? (rd != e_val) : (btn[e_idx] != e_pr);
  assign trig_tilt  = (e_val > 16'sd0);

  assign pass_gate = (axis_ok || btn_ok) && !gate_block;
  assign eval_need = pass_gate && changed && axis_ok && (e_idx < 4'd4);
  assign eval_cand = pass_gate && changed &&
                     (btn_ok || (axis_ok && (e_idx >= 4'd4) &&
                                 (trig_tilt || trig_t[e_idx[0]])));

  always_comb begin
    btn_next        = btn;
    btn_next[e_idx] = e_pr;
  end

  assign prod = rd * rd;
  assign ysx  = {{20{yr[15]}}, yr};
  assign xsx  = {{20{xr[15]}}, xr};
  assign u0   = (36'sd0 - ysx) <<< 16;
  assign v0   = xsx <<< 16;
  assign sq_t = sq_r + sq_bit;

  // dead zone terms: 32767*k written as (k<<15)-k
  assign a_s   = {sq_r[23:0], 15'd0};
  assign dz_m  = {dead_zone, 15'd0} - {15'd0, dead_zone};
  assign thr   = {dz_m, 8'd0};
  assign om    = 16'd32768 - {1'b0, dead_zone};
  assign den_m = {om, 15'd0} - {15'd0, om};
  assign den   = {den_m, 8'd0};
  assign num   = {1'b0, a_s - {1'b0, thr}, 15'd0};

  assign stick_dist = dzero ? 16'd0 : (dsat ? 16'hFFFF : q);
  assign acc_rnd    = acc + 32'h0000_8000;

  assign out_free    = !out_valid || out_ready;
  assign end_of_item = cmd.next && !sts.sub_more;

  assign sts.need_stick = need_stick;
  assign sts.cand_ok    = cand_ok;
  assign sts.iter_last  = (step == 5'(CORDIC_STEPS - 1));
  assign sts.div_last   = (step == 5'(DIV_STEPS - 1));
  assign sts.emit_ok    = !pend_v || out_free;
  assign sts.pend_v     = pend_v;
  assign sts.out_free   = out_free;
  assign sts.sub_more   = is_rm && (sub != 5'(LAST_SUB));

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r <= in_kind;
      idx_r  <= in_index;
      val_r  <= in_axis_value;
      pr_r   <= in_pressed;
      now_r  <= in_time_ms;
    end
    if (cmd.eval) begin
      st_sel <= e_idx[1];
    end
    if (cmd.mul0) begin
      xr <= rd;
      p  <= 32'(prod);
    end
    if (cmd.mul1) begin
      yr <= rd;
      p  <= 32'(prod);
      r2 <= p;
    end
    if (cmd.mul2) begin
      r2 <= r2 + p;
    end
    if (cmd.init) begin
      sq_n  <= {2'd0, r2, 16'd0};
      sq_r  <= '0;
      czero <= (xr == 16'sd0) && (yr == 16'sd0);
      if (u0 < 36'sd0) begin
        cu  <= 36'sd0 - u0;
        cv  <= 36'sd0 - v0;
        acc <= 32'h8000_0000;
      end else begin
        cu  <= u0;
        cv  <= v0;
        acc <= 32'd0;
      end
    end
    if (cmd.iter) begin
      if (!cv[35]) begin
        cu  <= cu + (cv >>> step);
        cv  <= cv - (cu >>> step);
        acc <= acc + atan_turn(step);
      end else begin
        cu  <= cu - (cv >>> step);
        cv  <= cv + (cu >>> step);
        acc <= acc - atan_turn(step);
      end
      if (sq_bit != '0) begin
        if (sq_n >= sq_t) begin
          sq_n <= sq_n - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
      end
    end
    if (cmd.dprep) begin
      dzero <= ({1'b0, thr} >= a_s);
      dsat  <= ({1'b0, num} >= {1'b0, den, 16'd0});
      rem   <= {1'b0, num};
      dsh   <= {2'd0, den, 15'd0};
      q     <= '0;
    end
    if (cmd.div) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[14:0], 1'b1};
      end else begin
        q   <= {q[14:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.emit) begin
      pend <= cand;
    end
    if (cmd.flush || (cmd.emit && pend_v)) begin
      out_res  <= pend;
      out_last <= cmd.flush;
    end
  end

  // step counter and sqrt bit mark carry control meaning
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      sq_bit <= '0;
    end else if (cmd.init || cmd.dprep) begin
      step   <= '0;
      sq_bit <= cmd.init ? (50'd1 << 48) : sq_bit;
    end else if (cmd.iter || cmd.div) begin
      step   <= step + 5'd1;
      sq_bit <= cmd.iter ? (sq_bit >> 2) : sq_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (end_of_item && is_rm)) begin
      for (int i = 0; i < AXIS_COUNT; i++) axis_store[i] <= 16'sd0;
      btn        <= '0;
      stick_t    <= '0;
      trig_t     <= '0;
      stamp      <= '0;
      present    <= 1'b0;
      need_stick <= 1'b0;
      cand_ok    <= 1'b0;
      sub        <= '0;
    end else begin
      if (cmd.take) begin
        sub <= '0;
      end
      if (cmd.next) begin
        cand_ok <= 1'b0;
        if (sts.sub_more) sub <= sub + 5'd1;
      end
      if (cmd.emit) begin
        cand_ok <= 1'b0;
      end
      if (cmd.eval) begin
        cand_ok    <= eval_cand;
        need_stick <= eval_need;
        if (e_kind == KIND_ATTACH) begin
          for (int i = 0; i < AXIS_COUNT; i++) axis_store[i] <= 16'sd0;
          btn     <= '0;
          stick_t <= '0;
          trig_t  <= '0;
          present <= 1'b1;
          stamp   <= now_r;
        end else if (pass_gate) begin
          stamp <= '0;
          if (changed && axis_ok) begin
            axis_store[e_idx[2:0]] <= e_val;
            if ((e_idx >= 4'd4) && (trig_tilt || trig_t[e_idx[0]])) begin
              trig_t[e_idx[0]] <= trig_tilt;
              cand    <= '{event_type: EV_TRIGGER, which: {3'd0, e_idx[0]},
                           is_pressed: 1'b0, direction: DIR_C, angle: 16'd0,
                           distance: 16'd0, trigger_level: e_val};
            end
          end else if (changed && btn_ok) begin
            btn     <= btn_next;
            if (e_idx <= 4'(LAST_PLAIN)) begin
              cand <= '{event_type: EV_BUTTON, which: e_idx, is_pressed: e_pr,
                        direction: DIR_C, angle: 16'd0, distance: 16'd0,
                        trigger_level: 16'sd0};
            end else begin
              cand <= '{event_type: EV_DPAD, which: 4'd0, is_pressed: 1'b0,
                        direction: dpad_dir(btn_next[BTN_UP], btn_next[BTN_DOWN],
                                            btn_next[BTN_LEFT], btn_next[BTN_RIGHT]),
                        angle: 16'd0, distance: 16'd0, trigger_level: 16'sd0};
            end
          end
        end
      end
      if (cmd.fin) begin
        need_stick <= 1'b0;
        if ((stick_dist != 16'd0) || stick_t[st_sel]) begin
          stick_t[st_sel] <= (stick_dist != 16'd0);
          cand_ok <= 1'b1;
          cand    <= '{event_type: EV_STICK, which: {3'd0, st_sel},
                       is_pressed: 1'b0, direction: DIR_C,
                       angle: czero ? 16'd0 : acc_rnd[31:16], distance: stick_dist,
                       trigger_level: 16'sd0};
        end
      end
    end
  end

  // result staging: the newest result waits in pend so its last flag is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.flush) begin
        pend_v    <= 1'b0;
        out_valid <= 1'b1;
      end else if (cmd.emit) begin
        pend_v    <= 1'b1;
        out_valid <= pend_v ? 1'b1 : (out_valid && !out_ready);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_sqrt_bit: assert property (@(posedge clk) disable iff (rst) $onehot0(sq_bit))
    else $error("sqrt bit mark not one-hot");
  a_move_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush || (cmd.emit && pend_v)) |-> out_free)
    else $error("output register overwritten while held");
  a_remove_clear: assert property (@(posedge clk) disable iff (rst)
    (end_of_item && is_rm) |=> (!present && (stamp == 32'd0)))
    else $error("remove left controller state behind");
  a_flush_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !pend_v)
    else $error("pending result kept after flush");
`endif

endmodule

// File: rtl/gamepad_event_conditioner.sv
`timescale 1ns / 1ps
// Top level of the gamepad event conditioner: stream ports, APB registers,
// sequencer and datapath. Depends on gec_pkg, gec_ctrl and gec_dp.
//
// Usage:
//  s_* carries one gamepad event per beat (kind in s_tuser). Each event yields
//  zero or more result beats on m_* (event type in m_tuser); m_tlast marks the
//  final result of an event. An event that yields no result gives no beat.
//  A stick event runs the multiply states MUL0 to MUL2, then 30 CORDIC
//  iterations that also carry the 25-step square root, and 16 divider steps.
//  A remove walks all 21 axes and buttons, with up to four stick recomputes,
//  the other results and one final hand-off.
//  One event is worked at a time; s_tready is high only while idle.
//  Results go through a one-deep holding stage and an output register, so a
//  new event is taken while the final result still waits on m_tready. A stall
//  on m_tready holds the sequencer at its next result hand-off.
//  Reset (rst, synchronous): no controller present, all axes zero, buttons
//  released, quiet window 200 ms, dead zone 16384. Registers are to be
//  written over APB only while the block is idle: 0x0 quiet window, 0x4 dead
//  zone; the block itself does not enforce this.
module gamepad_event_conditioner
  import gec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // index[3:0], axis_value[19:4], pressed[20],
                                 // time_ms[52:21], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // which[3:0], is_pressed[4], direction[8:5],
                                 // angle[24:9], distance[40:25],
                                 // trigger_level[56:41], zero pad
  output logic [1:0]  m_tuser,   // event_type[1:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] attach_quiet_ms;
  logic [14:0] dead_zone;
  logic        reg_sel;
  cmd_t        cmd;
  sts_t        sts;
  res_t        res;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_DZ) ? {17'd0, dead_zone} : {16'd0, attach_quiet_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      attach_quiet_ms <= 16'd200;
      dead_zone       <= 15'd16384;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == REG_QUIET) attach_quiet_ms <= pwdata[15:0];
      else                      dead_zone       <= pwdata[14:0];
    end
  end

  gec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gec_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (s_tuser),
    .in_index        (s_tdata[3:0]),
    .in_axis_value   (s_tdata[19:4]),
    .in_pressed      (s_tdata[20]),
    .in_time_ms      (s_tdata[52:21]),
    .attach_quiet_ms (attach_quiet_ms),
    .dead_zone       (dead_zone),
    .out_ready       (m_tready),
    .out_res         (res),
    .out_last        (m_tlast),
    .out_valid       (m_tvalid)
  );

  assign m_tuser = res.event_type;
  assign m_tdata = {7'd0, res.trigger_level, res.distance, res.angle,
                    res.direction, res.is_pressed, res.which};

endmodule

// File: sim/gamepad_event_conditioner_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gamepad_event_conditioner: random and directed events,
// with an event-level predictor and a result scoreboard. Depends on gec_pkg and the RTL.
module gamepad_event_conditioner_tb
  import gec_pkg::*;
();

  typedef struct {
    logic [1:0]  etype;
    logic [3:0]  which;
    logic        pr;
    logic [3:0]  dir;
    logic [15:0] ang;
    logic [15:0] mag;
    logic [15:0] trig;
    logic        last;
  } pad_res_t;

  class gamepad_scoreboard;
    pad_res_t pending[$];
    int errors;
    logic [15:0] quiet_ms;
    logic [14:0] dz;
    logic signed [15:0] axes[AXIS_COUNT];
    logic btns[BUTTON_COUNT];
    logic stick_on[2];
    logic trig_on[2];
    logic [31:0] stamp;
    logic attached;

    function new();
      errors = 0;
      quiet_ms = 16'd200;
      dz = 15'd16384;
      clear_pad();
    endfunction

    function void clear_pad();
      foreach (axes[i]) axes[i] = '0;
      foreach (btns[i]) btns[i] = 1'b0;
      stick_on[0] = 0; stick_on[1] = 0;
      trig_on[0] = 0; trig_on[1] = 0;
      stamp = '0;
      attached = 0;
    endfunction

    function bit gated(logic [31:0] now);
      logic [31:0] dt;
      dt = now - stamp;
      if (!attached) return 1;
      if (stamp != 0 && dt <= {16'd0, quiet_ms}) return 1;
      stamp = '0;
      return 0;
    endfunction

    function longint fshr(longint v, int s);
      return v >>> s;
    endfunction

    function logic [15:0] angle_of(longint x, longint y);
      longint u, v, t;
      logic [31:0] acc;
      u = -y * 65536;
      v = x * 65536;
      acc = '0;
      if (x == 0 && y == 0) return 16'd0;
      if (u < 0) begin
        u = -u; v = -v; acc = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (v >= 0) begin
          t = u + fshr(v, i); v = v - fshr(u, i); acc += atan_turn(i[4:0]);
        end else begin
          t = u - fshr(v, i); v = v + fshr(u, i); acc -= atan_turn(i[4:0]);
        end
        u = t;
      end
      acc = acc + 32'h8000;
      return acc[31:16];
    endfunction

    function logic [15:0] dist_of(longint x, longint y);
      longint unsigned n, r, b, thr, den, d, s;
      n = longint'(x * x + y * y) << 16;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      s = r;
      thr = 64'd32767 * dz * 256;
      if (32768 * s <= thr) return 16'd0;
      den = 64'd32767 * (64'd32768 - dz) * 256;
      d = ((32768 * s - thr) * 32768) / den;
      return d > 65535 ? 16'hFFFF : d[15:0];
    endfunction

    function void push(logic [1:0] t, logic [3:0] w, logic p, logic [3:0] dr,
                       logic [15:0] a, logic [15:0] ds, logic [15:0] tr);
      pad_res_t e;
      e.etype = t; e.which = w; e.pr = p; e.dir = dr;
      e.ang = a; e.mag = ds; e.trig = tr; e.last = 0;
      pending.push_back(e);
    endfunction

    function void axis_change(int ax, logic signed [15:0] val, logic [31:0] now);
      int st;
      logic [15:0] a, ds;
      if (gated(now) || axes[ax] == val) return;
      axes[ax] = val;
      if (ax < 4) begin
        st = ax / 2;
        a = angle_of(axes[st*2], axes[st*2+1]);
        ds = dist_of(axes[st*2], axes[st*2+1]);
        if (ds == 0 && !stick_on[st]) return;
        stick_on[st] = ds != 0;
        push(EV_STICK, st[3:0], 0, DIR_C, a, ds, '0);
      end else begin
        st = ax - 4;
        if (val <= 0 && !trig_on[st]) return;
        trig_on[st] = val > 0;
        push(EV_TRIGGER, st[3:0], 0, DIR_C, '0, '0, val);
      end
    endfunction

    function void button_change(int b, logic p, logic [31:0] now);
      if (gated(now) || btns[b] == p) return;
      btns[b] = p;
      if (b <= LAST_PLAIN) push(EV_BUTTON, b[3:0], p, DIR_C, '0, '0, '0);
      else push(EV_DPAD, 4'd0, 0, dpad_dir(btns[BTN_UP], btns[BTN_DOWN],
                btns[BTN_LEFT], btns[BTN_RIGHT]), '0, '0, '0);
    endfunction

    // note an accepted event and queue what it should produce
    function void note_event(logic [1:0] kind, logic [3:0] idx,
                             logic signed [15:0] val, logic p, logic [31:0] now);
      int n0;
      n0 = pending.size();
      case (kind)
        KIND_AXIS: if (idx < AXIS_COUNT) axis_change(idx, val, now);
        KIND_BUTTON: if (idx < BUTTON_COUNT) button_change(idx, p, now);
        KIND_ATTACH: begin
          clear_pad(); attached = 1; stamp = now;
        end
        default: if (attached) begin
          for (int i = 0; i < AXIS_COUNT; i++) axis_change(i, 16'sd0, now);
          for (int i = 0; i < BUTTON_COUNT; i++) button_change(i, 0, now);
          clear_pad();
        end
      endcase
      if (pending.size() > n0) pending[pending.size()-1].last = 1;
    endfunction

    function void check_result(logic [1:0] t, logic [63:0] d, logic l);
      pad_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat type %0d data %h", t, d);
        return;
      end
      e = pending.pop_front();
      if (t !== e.etype || d[3:0] !== e.which || d[4] !== e.pr || d[8:5] !== e.dir ||
          d[24:9] !== e.ang || d[40:25] !== e.mag || d[56:41] !== e.trig ||
          d[63:57] !== '0 || l !== e.last) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: exp t%0d w%0d p%0d d%0d a%0d r%0d g%0d l%0d",
                    " got t%0d w%0d p%0d d%0d a%0d r%0d g%0d l%0d"},
                   e.etype, e.which, e.pr, e.dir, e.ang, e.mag, $signed(e.trig),
                   e.last, t, d[3:0], d[4], d[8:5], d[24:9], d[40:25],
                   $signed(d[56:41]), l);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, m_tlast, pready;
  logic [55:0] s_tdata = '0;
  logic [1:0] s_tuser = '0, m_tuser;
  logic [63:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  gamepad_event_conditioner u_dut (.*);

  always #5 clk = ~clk;

  gamepad_scoreboard sb = new();
  int src_idle_pct = 0, snk_idle_pct = 0;
  bit sink_hold = 0;
  longint cycles = 0;
  logic [31:0] clock_ms = 32'd1000;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: sample and check at the edge, then choose next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    m_tready <= !rst && !sink_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic write_reg(logic reg_sel, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_sel, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (reg_sel == REG_QUIET) sb.quiet_ms = v[15:0];
    else sb.dz = v[14:0];
  endtask

  // valid stays up after a beat until the next beat replaces it or an idle gap or drain drops it
  task automatic send_event(logic [1:0] kind, logic [3:0] idx,
                            logic signed [15:0] val, logic p, logic [31:0] now);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= kind;
    s_tdata <= {3'b0, now, p, val, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_event(kind, idx, val, p, now);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sd0;
      3: return 16'($urandom_range(2000) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly axis and button activity, with occasional attach, remove and out-of-range index
  task automatic random_event();
    int r;
    r = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(60);
    if (r < 4) send_event(KIND_ATTACH, 4'($urandom), 16'($urandom), 1'($urandom),
                          clock_ms);
    else if (r < 9) send_event(KIND_REMOVE, 4'($urandom), 16'($urandom), 1'($urandom),
                               clock_ms);
    else if (r < 12) send_event(2'($urandom_range(1)), 4'd15, 16'($urandom),
                                1'($urandom), clock_ms);
    else if (r < 55) send_event(KIND_AXIS, 4'($urandom_range(5)), rand_axis(),
                                1'($urandom), clock_ms);
    else send_event(KIND_BUTTON, 4'($urandom_range(14)), 16'($urandom), 1'($urandom),
                    clock_ms);
  endtask

  task automatic random_phase(int n);
    send_event(KIND_ATTACH, 0, 0, 0, clock_ms);
    clock_ms += 300;
    for (int i = 0; i < n; i++) random_event();
    send_event(KIND_REMOVE, 0, 0, 0, clock_ms);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: gate while absent, attach at time 0, extremes, dpad, remove
    send_event(KIND_AXIS, 0, 16'sd500, 0, 32'd5);
    send_event(KIND_ATTACH, 0, 0, 0, 32'd0);
    send_event(KIND_AXIS, 0, 16'sh7FFF, 0, 32'd1);
    send_event(KIND_AXIS, 1, 16'sh8000, 0, 32'd2);
    send_event(KIND_AXIS, 1, 16'sh8000, 0, 32'd3);
    send_event(KIND_AXIS, 2, 16'sd100, 0, 32'd3);
    send_event(KIND_AXIS, 4, 16'sh7FFF, 0, 32'd4);
    send_event(KIND_AXIS, 4, 16'sh8000, 0, 32'd4);
    send_event(KIND_AXIS, 4, 16'sd0, 0, 32'd4);
    send_event(KIND_AXIS, 7, 16'sd9, 0, 32'd4);
    send_event(KIND_BUTTON, 15, 0, 1, 32'd5);
    send_event(KIND_BUTTON, 0, 0, 1, 32'd5);
    send_event(KIND_BUTTON, 10, 0, 1, 32'd5);
    send_event(KIND_BUTTON, BTN_UP, 0, 1, 32'd6);
    send_event(KIND_BUTTON, BTN_LEFT, 0, 1, 32'd6);
    send_event(KIND_BUTTON, BTN_RIGHT, 0, 1, 32'd6);
    send_event(KIND_BUTTON, BTN_DOWN, 0, 1, 32'd6);
    send_event(KIND_REMOVE, 0, 0, 0, 32'hFFFF_FFFF);
    send_event(KIND_REMOVE, 0, 0, 0, 32'd7);
    // quiet window edge with wrapping time
    send_event(KIND_ATTACH, 0, 0, 0, 32'hFFFF_FF00);
    send_event(KIND_BUTTON, 1, 0, 1, 32'h0000_0008);
    send_event(KIND_BUTTON, 1, 0, 1, 32'h0000_0009);
    send_event(KIND_AXIS, 5, 16'sd1, 0, 32'd20);
    send_event(KIND_REMOVE, 0, 0, 0, 32'd21);
    drain();

    src_idle_pct = 15; snk_idle_pct = 83;
    write_reg(REG_QUIET, 32'd0); write_reg(REG_DZ, 32'd0);
    random_phase(120);
    // long receiver stall while events keep coming
    fork
      begin
        sink_hold = 1;
        repeat (3000) @(posedge clk);
        sink_hold = 0;
      end
      random_phase(40);
    join
    src_idle_pct = 83; snk_idle_pct = 15;
    write_reg(REG_QUIET, 32'd65535); write_reg(REG_DZ, 32'd32767);
    send_event(KIND_ATTACH, 0, 0, 0, clock_ms);
    send_event(KIND_AXIS, 0, 16'sh7FFF, 0, clock_ms + 65535);
    send_event(KIND_AXIS, 0, 16'sh7FFF, 0, clock_ms + 65536);
    send_event(KIND_REMOVE, 0, 0, 0, clock_ms + 65537);
    clock_ms += 70000;
    drain();
    write_reg(REG_QUIET, $urandom_range(100)); write_reg(REG_DZ, $urandom_range(32767));
    random_phase(120);
    src_idle_pct = 0; snk_idle_pct = 0;
    write_reg(REG_QUIET, 32'd200); write_reg(REG_DZ, 32'd8000);
    random_phase(170);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/gec_pkg.sv
rtl/gec_ctrl.sv
rtl/gec_dp.sv
rtl/gamepad_event_conditioner.sv
sim/gamepad_event_conditioner_tb.sv
